/* src/hsd_pkg.sv */
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types and constants for the stream dedup hash set: table sizes,
// derived widths, modulo folding constants and the item and result structs.
// ----------------------------------------------------------------------------
package hsd_pkg;

  localparam int VALUE_W  = 32;
  localparam int BUCKETS  = 1021;
  localparam int CAPACITY = 1024;

  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int NODE_W   = $clog2(CAPACITY);
  localparam int LINK_W   = $clog2(CAPACITY + 1);
  localparam int COUNT_W  = 11;
  localparam int EPOCH_W  = 4;
  localparam int HEAD_W   = EPOCH_W + LINK_W;

  // fold register holds one carry bit above the value
  localparam int XW = VALUE_W + 1;

  // 2^BUCKET_W mod BUCKETS, multiplier for folding the upper part down
  localparam int FOLD_MUL = (1 << BUCKET_W) % BUCKETS;
  // 2^32 mod BUCKETS, correction for negative values
  localparam longint unsigned NEG_ADJ_L = (64'd1 << VALUE_W) % BUCKETS;
  localparam int NEG_ADJ = int'(NEG_ADJ_L);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      start_of_set;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    logic [COUNT_W-1:0]        distinct_count;
    logic                      pool_full;
  } result_t;

endpackage

/* src/hash_set_stream_dedup.sv */
// ----------------------------------------------------------------------------
// hash_set_stream_dedup
// First-occurrence filter over signed 32-bit values, built on a chained hash
// set with a fixed node pool and a small sequencer around one fold unit.
// ----------------------------------------------------------------------------
// Usage: drive item and raise start while busy is low; the transaction is
// taken at that edge and busy stays high until the item is finished. A new
// value produces one result, shown for one cycle with result_valid high; a
// repeated value produces nothing. The receiver cannot stall the block.
// Steps per item: accept, folding the value modulo the bucket count in the
// shared fold unit, the sign correction and head read, the head check, the
// chain walk (one node memory read per cycle), and the insert and emit step.
// start_of_set empties the set by bumping an epoch tag kept with each head;
// every 16th such clear wraps the tag and sweeps the head memory first,
// writing all BUCKETS (1021) heads.
// Reset: synchronous, active high. After reset the head memory is swept
// with busy high before the first item is taken.
// ----------------------------------------------------------------------------
module hash_set_stream_dedup
  import hsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    result_valid,
  output result_t result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_FOLD  = 3'd2;
  localparam logic [2:0] S_ADJ   = 3'd3;
  localparam logic [2:0] S_HEAD  = 3'd4;
  localparam logic [2:0] S_WALK  = 3'd5;
  localparam logic [2:0] S_NEW   = 3'd6;

  logic [2:0]          state;
  logic [VALUE_W-1:0]  value_q;
  logic [XW-1:0]       x;
  logic [BUCKET_W-1:0] bucket;
  logic [LINK_W-1:0]   head_link;
  logic [LINK_W-1:0]   nodes_used;
  logic [EPOCH_W-1:0]  epoch;
  logic [BUCKET_W-1:0] clr_addr;
  logic                clr_pending;

  logic [HEAD_W-1:0]   head_mem [BUCKETS];
  logic [VALUE_W-1:0]  node_val_mem [CAPACITY];
  logic [LINK_W-1:0]   node_link_mem [CAPACITY];
  logic [HEAD_W-1:0]   head_rd;
  logic [VALUE_W-1:0]  nval_rd;
  logic [LINK_W-1:0]   nlink_rd;

  logic                accept;
  logic [EPOCH_W-1:0]  epoch_inc;
  logic [XW-BUCKET_W-1:0] fold_hi;
  logic [BUCKET_W-1:0] fold_lo;
  logic [XW-1:0]       fold_sum;
  logic [XW-1:0]       fold_red;
  logic [BUCKET_W:0]   adj_r;
  logic [BUCKET_W-1:0] bucket_calc;
  logic [LINK_W-1:0]   head_live;
  logic [LINK_W-1:0]   link_sel;
  logic [NODE_W-1:0]   node_raddr;
  logic                pool_has_room;
  logic                head_we;
  logic [BUCKET_W-1:0] head_waddr;
  logic [HEAD_W-1:0]   head_wdata;
  logic                node_we;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign epoch_inc = epoch + EPOCH_W'(1);

  // shared fold unit: x -> hi * (2^BUCKET_W mod BUCKETS) + lo
  assign fold_hi  = x[XW-1:BUCKET_W];
  assign fold_lo  = x[BUCKET_W-1:0];
  assign fold_sum = XW'(fold_hi) * XW'(FOLD_MUL) + XW'(fold_lo);
  assign fold_red = (x >= XW'(BUCKETS)) ? x - XW'(BUCKETS) : x;

  // non-negative bucket: remove 2^32 mod BUCKETS for negative values
  always_comb begin
    adj_r = (BUCKET_W+1)'(x[BUCKET_W-1:0]);
    if (value_q[VALUE_W-1]) begin
      if (adj_r >= (BUCKET_W+1)'(NEG_ADJ)) begin
        adj_r = adj_r - (BUCKET_W+1)'(NEG_ADJ);
      end else begin
        adj_r = adj_r + (BUCKET_W+1)'(BUCKETS - NEG_ADJ);
      end
    end
    bucket_calc = adj_r[BUCKET_W-1:0];
  end

  assign head_live = (head_rd[HEAD_W-1:LINK_W] == epoch) ? head_rd[LINK_W-1:0] : '0;
  assign link_sel  = (state == S_HEAD) ? head_live : nlink_rd;
  assign node_raddr = NODE_W'(link_sel - LINK_W'(1));
  assign pool_has_room = (nodes_used < LINK_W'(CAPACITY));

  always_comb begin
    head_we    = 1'b0;
    head_waddr = bucket;
    head_wdata = {epoch, nodes_used + LINK_W'(1)};
    node_we    = 1'b0;
    if (state == S_CLEAR) begin
      head_we    = 1'b1;
      head_waddr = clr_addr;
      head_wdata = {epoch, LINK_W'(0)};
    end else if (state == S_NEW && pool_has_room) begin
      head_we = 1'b1;
      node_we = 1'b1;
    end
  end

  // head memory
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rd <= head_mem[bucket_calc];
  end

  // node pool memories
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_val_mem[nodes_used[NODE_W-1:0]]  <= value_q;
      node_link_mem[nodes_used[NODE_W-1:0]] <= head_link;
    end
    nval_rd  <= node_val_mem[node_raddr];
    nlink_rd <= node_link_mem[node_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      nodes_used   <= '0;
      epoch        <= '0;
      clr_addr     <= '0;
      clr_pending  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            value_q <= item.value;
            x       <= {1'b0, item.value};
            if (item.start_of_set) begin
              nodes_used <= '0;
              epoch      <= epoch_inc;
              if (epoch_inc == '0) begin
                clr_addr    <= '0;
                clr_pending <= 1'b1;
                state       <= S_CLEAR;
              end else begin
                state <= S_FOLD;
              end
            end else begin
              state <= S_FOLD;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + BUCKET_W'(1);
          if (clr_addr == BUCKET_W'(BUCKETS - 1)) begin
            clr_pending <= 1'b0;
            state       <= clr_pending ? S_FOLD : S_IDLE;
          end
        end
        S_FOLD: begin
          if (fold_hi != '0) begin
            x <= fold_sum;
          end else begin
            x     <= fold_red;
            state <= S_ADJ;
          end
        end
        S_ADJ: begin
          bucket <= bucket_calc;
          state  <= S_HEAD;
        end
        S_HEAD: begin
          head_link <= head_live;
          state     <= (head_live == '0) ? S_NEW : S_WALK;
        end
        S_WALK: begin
          if (nval_rd == value_q) begin
            state <= S_IDLE;
          end else if (nlink_rd == '0) begin
            state <= S_NEW;
          end
        end
        S_NEW: begin
          result_valid     <= 1'b1;
          result.value_out <= value_q;
          if (pool_has_room) begin
            nodes_used            <= nodes_used + LINK_W'(1);
            result.distinct_count <= COUNT_W'(nodes_used + LINK_W'(1));
            result.pool_full      <= 1'b0;
          end else begin
            result.distinct_count <= COUNT_W'(nodes_used);
            result.pool_full      <= 1'b1;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
